/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define NAPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must never hold on a clock edge outside reset.
`define NAPM_ASSERT_NEVER(lbl, expr, msg) \
  `NAPM_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/napm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napm_pkg
// Types, constants and helpers for the pattern match statistics unit.
// ----------------------------------------------------------------------------
package napm_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned MaxText    = 65536;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PatternW = MaxPattern * ByteW;
  localparam int unsigned LenW     = 4;
  localparam int unsigned WinIdxW  = $clog2(MaxPattern);
  localparam int unsigned PosW     = $clog2(MaxText + 1);
  localparam int unsigned OffsetW  = 16;
  localparam int unsigned CountW   = 17;
  localparam int unsigned CompareW = 20;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPatternBytes  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegPatternLength = CfgIdxW'(1);

  localparam logic [LenW-1:0]     LenReset   = LenW'(1);
  localparam logic [CountW-1:0]   CountMax   = {CountW{1'b1}};
  localparam logic [CompareW-1:0] CompareMax = {CompareW{1'b1}};

  // One completed alignment
  typedef struct packed {
    logic               done;   // an alignment completed with this byte
    logic               full;   // whole pattern matched
    logic [LenW-1:0]    len;    // leading match length
    logic [OffsetW-1:0] start;  // alignment offset, modulo 2^16
  } align_t;

  // One result transaction
  typedef struct packed {
    logic                found;
    logic [OffsetW-1:0]  first_offset;
    logic [OffsetW-1:0]  last_offset;
    logic [CountW-1:0]   match_count;
    logic [LenW-1:0]     longest_match;
    logic [CompareW-1:0] compared_count;
    logic                overflow;
  } result_t;

  // Clamp the programmed length into 1..MaxPattern
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] raw);
    logic [LenW-1:0] m;
    m = raw;
    if (m == '0) m = LenW'(1);
    if (m > LenW'(MaxPattern)) m = LenW'(MaxPattern);
    return m;
  endfunction

endpackage

/* rtl/napm_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napm_scan
// Text window, byte position and the parallel left-to-right compare.
// ----------------------------------------------------------------------------
module napm_scan (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [napm_pkg::ByteW-1:0]        text_byte_i,
  input  logic                              has_byte_i,
  input  logic                              end_of_text_i,
  input  logic [napm_pkg::PatternW-1:0]     pattern_i,
  input  logic [napm_pkg::LenW-1:0]         length_i,
  output napm_pkg::align_t                  align_o,
  output logic                              overflow_o
);

  logic [napm_pkg::ByteW-1:0] win_q [napm_pkg::MaxPattern];
  logic [napm_pkg::ByteW-1:0] win_d [napm_pkg::MaxPattern];
  logic [napm_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       ovf_q, ovf_d;
  logic                       take;
  logic [napm_pkg::LenW-1:0]  m;
  logic [napm_pkg::MaxPattern-1:0] eq;
  logic [napm_pkg::LenW-1:0]  len;
  logic                       run;
  logic [napm_pkg::WinIdxW-1:0] age;

  assign take = has_byte_i && (pos_q < napm_pkg::PosW'(napm_pkg::MaxText));
  assign m    = napm_pkg::eff_len(length_i);

  // Shifted window: newest byte at age zero
  always_comb begin
    for (int k = 0; k < napm_pkg::MaxPattern; k++) begin
      if (take) begin
        win_d[k] = (k == 0) ? text_byte_i : win_q[(k == 0) ? 0 : k - 1];
      end else begin
        win_d[k] = win_q[k];
      end
    end
    pos_d = take ? pos_q + napm_pkg::PosW'(1) : pos_q;
    ovf_d = ovf_q | (has_byte_i & ~take);
  end

  // Pattern byte k against text byte at age m-1-k
  always_comb begin
    age = '0;
    for (int k = 0; k < napm_pkg::MaxPattern; k++) begin
      age   = napm_pkg::WinIdxW'(m - napm_pkg::LenW'(1) - napm_pkg::LenW'(k));
      eq[k] = (pattern_i[k*napm_pkg::ByteW +: napm_pkg::ByteW] == win_d[age]);
    end
  end

  // Leading run of matches, cut at m
  always_comb begin
    len = '0;
    run = 1'b1;
    for (int k = 0; k < napm_pkg::MaxPattern; k++) begin
      if (run && (napm_pkg::LenW'(k) < m) && eq[k]) begin
        len = len + napm_pkg::LenW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    align_o.done  = take && (pos_d >= napm_pkg::PosW'(m));
    align_o.full  = (len == m);
    align_o.len   = len;
    align_o.start = napm_pkg::OffsetW'(pos_d - napm_pkg::PosW'(m));
  end

  assign overflow_o = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < napm_pkg::MaxPattern; k++) win_q[k] <= '0;
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else if (fire_i) begin
      // Drop all text state when the end-of-text item fires
      for (int k = 0; k < napm_pkg::MaxPattern; k++) begin
        win_q[k] <= end_of_text_i ? '0 : win_d[k];
      end
      pos_q <= end_of_text_i ? '0 : pos_d;
      ovf_q <= end_of_text_i ? 1'b0 : ovf_d;
    end
  end

endmodule

/* rtl/napm_stats.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napm_stats
// Running statistics over completed alignments.
// ----------------------------------------------------------------------------
module napm_stats (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 end_of_text_i,
  input  napm_pkg::align_t     align_i,
  input  logic                 overflow_i,
  output napm_pkg::result_t    result_o
);

  logic                              seen_q, seen_d;
  logic [napm_pkg::OffsetW-1:0]      first_q, first_d;
  logic [napm_pkg::OffsetW-1:0]      last_q, last_d;
  logic [napm_pkg::CountW-1:0]       count_q, count_d;
  logic [napm_pkg::LenW-1:0]         best_q, best_d;
  logic [napm_pkg::CompareW-1:0]     total_q, total_d;
  logic [napm_pkg::LenW-1:0]         addend;
  logic [napm_pkg::CompareW:0]       sum;

  always_comb begin
    seen_d  = seen_q;
    first_d = first_q;
    last_d  = last_q;
    count_d = count_q;
    best_d  = best_q;
    total_d = total_q;
    addend  = align_i.full ? align_i.len : align_i.len + napm_pkg::LenW'(1);
    sum     = {1'b0, total_q} + (napm_pkg::CompareW + 1)'(addend);
    if (align_i.done) begin
      if (align_i.len > best_q) best_d = align_i.len;
      if (align_i.full) begin
        if (!seen_q) first_d = align_i.start;
        seen_d = 1'b1;
        last_d = align_i.start;
        if (count_q != napm_pkg::CountMax) count_d = count_q + napm_pkg::CountW'(1);
      end
      total_d = (sum > (napm_pkg::CompareW + 1)'(napm_pkg::CompareMax)) ?
                napm_pkg::CompareMax : sum[napm_pkg::CompareW-1:0];
    end
  end

  always_comb begin
    result_o.found          = seen_d;
    result_o.first_offset   = first_d;
    result_o.last_offset    = last_d;
    result_o.match_count    = count_d;
    result_o.longest_match  = best_d;
    result_o.compared_count = total_d;
    result_o.overflow       = overflow_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
      count_q <= '0;
      best_q  <= '0;
      total_q <= '0;
    end else if (fire_i) begin
      if (end_of_text_i) begin
        seen_q  <= 1'b0;
        first_q <= '0;
        last_q  <= '0;
        count_q <= '0;
        best_q  <= '0;
        total_q <= '0;
      end else begin
        seen_q  <= seen_d;
        first_q <= first_d;
        last_q  <= last_d;
        count_q <= count_d;
        best_q  <= best_d;
        total_q <= total_d;
      end
    end
  end

endmodule

/* rtl/naive_pattern_match_stats_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naive_pattern_match_stats_unit
// Streams text bytes past a programmed pattern of up to eight bytes and
// reports match statistics when the text ends.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ------------------------------
//  cfg       in         cfg_we_i                  cfg_index_i, cfg_data_i
//  in        in         in_valid_i / in_stall_o   text_byte_i, has_byte_i,
//                                                 end_of_text_i
//  out       out        out_valid_o / out_stall_i found_o .. overflow_o
//
//  One transaction per cycle unless the input side stalls: the input register
//  feeds the window shift, the eight-lane compare and the statistics update
//  combinationally. A result is loaded into the output register when its
//  final item fires from the input register.
//  Reset (rst_ni low) clears the text state, the pattern to zero, length 1.
//  Stalls: the input side stalls only when an end-of-text item waits behind
//  a result that the output side has not yet taken.
//
module naive_pattern_match_stats_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [napm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [napm_pkg::CfgDataW-1:0]   cfg_data_i,
  // text input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [napm_pkg::ByteW-1:0]      text_byte_i,
  input  logic                            has_byte_i,
  input  logic                            end_of_text_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [napm_pkg::OffsetW-1:0]    first_offset_o,
  output logic [napm_pkg::OffsetW-1:0]    last_offset_o,
  output logic [napm_pkg::CountW-1:0]     match_count_o,
  output logic [napm_pkg::LenW-1:0]       longest_match_o,
  output logic [napm_pkg::CompareW-1:0]   compared_count_o,
  output logic                            overflow_o
);

  // Configuration registers
  logic [napm_pkg::PatternW-1:0] pattern_q;
  logic [napm_pkg::LenW-1:0]     plen_q;

  // Input register
  logic                          s1_valid_q;
  logic [napm_pkg::ByteW-1:0]    s1_byte_q;
  logic                          s1_has_q;
  logic                          s1_end_q;

  // Output register
  logic                          out_valid_q;
  napm_pkg::result_t             out_q;

  logic                          in_accept;
  logic                          s1_adv;
  logic                          s1_fire;
  napm_pkg::align_t              align;
  logic                          ovf_next;
  napm_pkg::result_t             result;

  // Hold the final item only while the previous result still sits stalled
  assign s1_adv     = ~(s1_end_q & out_valid_q & out_stall_i);
  assign s1_fire    = s1_valid_q & s1_adv;
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= napm_pkg::LenReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == napm_pkg::RegPatternBytes) begin
        pattern_q <= cfg_data_i[napm_pkg::PatternW-1:0];
      end else if (cfg_index_i == napm_pkg::RegPatternLength) begin
        plen_q <= cfg_data_i[napm_pkg::LenW-1:0];
      end
    end
  end

  // Capture each transaction; it fires from here into the compare once it may advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= text_byte_i;
      s1_has_q  <= has_byte_i;
      s1_end_q  <= end_of_text_i;
    end
  end

  napm_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .text_byte_i  (s1_byte_q),
    .has_byte_i   (s1_has_q),
    .end_of_text_i(s1_end_q),
    .pattern_i    (pattern_q),
    .length_i     (plen_q),
    .align_o      (align),
    .overflow_o   (ovf_next)
  );

  napm_stats u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .end_of_text_i(s1_end_q),
    .align_i      (align),
    .overflow_i   (ovf_next),
    .result_o     (result)
  );

  // Result register: load on a final item, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_end_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_end_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = out_q.found;
  assign first_offset_o   = out_q.first_offset;
  assign last_offset_o    = out_q.last_offset;
  assign match_count_o    = out_q.match_count;
  assign longest_match_o  = out_q.longest_match;
  assign compared_count_o = out_q.compared_count;
  assign overflow_o       = out_q.overflow;

endmodule

/* rtl/napm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// napm_checker
// Port-level checks on the pattern match statistics unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module napm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            found_o,
  input logic [napm_pkg::OffsetW-1:0]    first_offset_o,
  input logic [napm_pkg::OffsetW-1:0]    last_offset_o,
  input logic [napm_pkg::CountW-1:0]     match_count_o,
  input logic [napm_pkg::LenW-1:0]       longest_match_o
);

  // Hold a stalled result transaction
  `NAPM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(match_count_o) && $stable(first_offset_o), "stalled result changed")

  // No match means empty offsets and count
  `NAPM_ASSERT(a_nomatch_zero, out_valid_o && !found_o |-> first_offset_o == '0 && last_offset_o == '0 && match_count_o == '0, "statistics without a match")

  // A match implies a nonzero count and a nonzero longest match
  `NAPM_ASSERT(a_match_count, out_valid_o && found_o |-> match_count_o != '0 && longest_match_o != '0, "match with empty count")

  // Input stalls only behind a stalled result
  `NAPM_ASSERT_NEVER(a_stall_cause, in_stall_o && !(out_valid_o && out_stall_i), "input stalled without cause")

endmodule

bind naive_pattern_match_stats_unit napm_checker u_napm_checker (.*);
